// ===== sv/vtgd_pkg.sv =====
// Shared types and codes for the vector tile geometry decoder.
`timescale 1ns / 1ps

package vtgd_pkg;

	// Configuration register indexes
	localparam logic [2:0] CFG_ORIGIN_X   = 3'd0;
	localparam logic [2:0] CFG_ORIGIN_Y   = 3'd1;
	localparam logic [2:0] CFG_SCALE      = 3'd2;
	localparam logic [2:0] CFG_GEOM_TYPE  = 3'd3;
	localparam logic [2:0] CFG_VERTEX_CAP = 3'd4;

	// Result event codes
	localparam logic [1:0] EV_VERTEX = 2'd0;
	localparam logic [1:0] EV_MARKER = 2'd1;
	localparam logic [1:0] EV_LINE   = 2'd2;
	localparam logic [1:0] EV_POLY   = 2'd3;

	// Geometry types
	localparam logic [1:0] GEOM_UNKNOWN = 2'd0;
	localparam logic [1:0] GEOM_POINT   = 2'd1;
	localparam logic [1:0] GEOM_LINE    = 2'd2;
	localparam logic [1:0] GEOM_POLYGON = 2'd3;

	// Command ids
	localparam logic [2:0] CMD_NONE   = 3'd0;
	localparam logic [2:0] CMD_MOVETO = 3'd1;
	localparam logic [2:0] CMD_LINETO = 3'd2;
	localparam logic [2:0] CMD_CLOSE  = 3'd7;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_req_t;

	typedef struct packed {
		logic [1:0]         event_res;
		logic signed [31:0] pixel_x;
		logic signed [31:0] pixel_y;
		logic [15:0]        path_vertices;
		logic               run_last;
	} out_res_t;

	// Up to two results per byte: a point (vertex or marker) first, then a flush
	typedef struct packed {
		logic        pt_valid;
		logic [1:0]  pt_kind;
		logic [15:0] pt_count;
		logic        fl_valid;
		logic [1:0]  fl_kind;
		logic [15:0] fl_count;
	} ev_meta_t;

endpackage

// ===== sv/vtgd_parser.sv =====
// Varint assembly, command decoding, cursor and path state, first pipeline stage.
`timescale 1ns / 1ps

module vtgd_parser
	import vtgd_pkg::*;
#(
	parameter int MAX_VERTEX_CAP = 65535
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  in_req_t     req,
	input  logic        ready_s1,
	input  logic [1:0]  geometry_type,
	input  logic [15:0] vertex_cap,
	output logic        valid_s1,
	output ev_meta_t    meta_s1,
	output logic [31:0] cursor_x_s1,
	output logic [31:0] cursor_y_s1
);

	localparam logic [1:0] PH_CMD = 2'd0;
	localparam logic [1:0] PH_X   = 2'd1;
	localparam logic [1:0] PH_Y   = 2'd2;
	localparam logic [15:0] MaxCap = 16'(MAX_VERTEX_CAP);

	// Only bits 34..0 of a varint are ever looked at (32-bit delta, count in 34..3)
	logic [34:0] acc_q, acc_n, acc_new;
	logic [5:0]  shift_q, shift_n;
	logic [1:0]  phase_q, phase_n;
	logic [2:0]  cmd_q, cmd_n;
	logic [31:0] rep_q, rep_n;
	logic [31:0] cx_q, cx_n, cy_q, cy_n;
	logic [15:0] vc_q, vc_n;
	logic [31:0] delta;
	logic [31:0] pcx, pcy;
	logic [15:0] cap;
	logic        more;
	logic        take;
	ev_meta_t    meta;

	assign cap = (vertex_cap < MaxCap) ? vertex_cap : MaxCap;

	always_comb begin
		acc_new = acc_q | (35'(req.data_byte[6:0]) << shift_q);
		more    = req.data_byte[7] && (shift_q <= 6'd56) && !req.last_byte;
		delta   = (acc_new[31:0] >> 1) ^ {32{acc_new[0]}};
		acc_n   = acc_q;
		shift_n = shift_q;
		phase_n = phase_q;
		cmd_n   = cmd_q;
		rep_n   = rep_q;
		cx_n    = cx_q;
		cy_n    = cy_q;
		vc_n    = vc_q;
		take    = 1'b0;
		meta    = '0;
		pcx     = cx_q;
		pcy     = cy_q;
		if (accept) begin
			if (more) begin
				acc_n   = acc_new;
				shift_n = shift_q + 6'd7;
			end else begin
				acc_n   = '0;
				shift_n = '0;
				unique case (phase_q)
					PH_X: begin
						cx_n    = cx_q + delta;
						phase_n = PH_Y;
						take    = req.last_byte;
					end
					PH_Y: begin
						cy_n = cy_q + delta;
						take = 1'b1;
					end
					default: begin
						phase_n = PH_CMD;
						if (acc_new[2:0] == CMD_MOVETO) begin
							if (geometry_type == GEOM_LINE && vc_q >= 16'd2) begin
								meta.fl_valid = 1'b1;
								meta.fl_kind  = EV_LINE;
								meta.fl_count = vc_q;
							end
							vc_n    = '0;
							cmd_n   = CMD_MOVETO;
							rep_n   = acc_new[34:3];
							phase_n = (acc_new[34:3] != '0) ? PH_X : PH_CMD;
						end else if (acc_new[2:0] == CMD_LINETO) begin
							cmd_n   = CMD_LINETO;
							rep_n   = acc_new[34:3];
							phase_n = (acc_new[34:3] != '0) ? PH_X : PH_CMD;
						end else if (acc_new[2:0] == CMD_CLOSE) begin
							if (geometry_type == GEOM_POLYGON && vc_q >= 16'd3) begin
								meta.fl_valid = 1'b1;
								meta.fl_kind  = EV_POLY;
								meta.fl_count = vc_q;
							end
							vc_n = '0;
						end
					end
				endcase
				pcx = cx_n;
				pcy = cy_n;
				if (take) begin
					if (cmd_q == CMD_MOVETO && geometry_type == GEOM_POINT) begin
						meta.pt_valid = 1'b1;
						meta.pt_kind  = EV_MARKER;
						meta.pt_count = '0;
					end else if (vc_q < cap) begin
						vc_n          = vc_q + 16'd1;
						meta.pt_valid = 1'b1;
						meta.pt_kind  = EV_VERTEX;
						meta.pt_count = vc_q + 16'd1;
					end
					rep_n   = rep_q - 32'd1;
					phase_n = (rep_q != 32'd1) ? PH_X : PH_CMD;
				end
				if (req.last_byte) begin
					if (!meta.fl_valid && geometry_type == GEOM_LINE && vc_n >= 16'd2) begin
						meta.fl_valid = 1'b1;
						meta.fl_kind  = EV_LINE;
						meta.fl_count = vc_n;
					end
					phase_n = PH_CMD;
					cmd_n   = CMD_NONE;
					rep_n   = '0;
					cx_n    = '0;
					cy_n    = '0;
					vc_n    = '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			shift_q  <= '0;
			phase_q  <= PH_CMD;
			cmd_q    <= CMD_NONE;
			rep_q    <= '0;
			cx_q     <= '0;
			cy_q     <= '0;
			vc_q     <= '0;
			valid_s1 <= 1'b0;
		end else begin
			acc_q   <= acc_n;
			shift_q <= shift_n;
			phase_q <= phase_n;
			cmd_q   <= cmd_n;
			rep_q   <= rep_n;
			cx_q    <= cx_n;
			cy_q    <= cy_n;
			vc_q    <= vc_n;
			if (ready_s1) begin
				valid_s1 <= accept && (meta.pt_valid || meta.fl_valid);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1) begin
			meta_s1     <= meta;
			cursor_x_s1 <= pcx;
			cursor_y_s1 <= pcy;
		end
	end

endmodule

// ===== sv/vtgd_scaler.sv =====
// One axis of the pixel mapping: multiply, add origin, truncate and saturate.
`timescale 1ns / 1ps

module vtgd_scaler (
	input  logic        clk,
	input  logic        ld_s2,
	input  logic        ld_s3,
	input  logic [31:0] cursor_s1,
	input  logic [31:0] scale,
	input  logic [31:0] origin,
	output logic [31:0] pixel
);

	localparam logic [31:0] PixMax = 32'h7fff_ffff;
	localparam logic [31:0] PixMin = 32'h8000_0000;

	logic signed [64:0] prod;
	logic [63:0]        prod_s2;
	logic [63:0]        sum_s3;
	logic signed [47:0] floor_q;
	logic [47:0]        q;

	// signed cursor times unsigned scale; the product always fits 64 bits
	assign prod = $signed(cursor_s1) * $signed({1'b0, scale});

	always_ff @(posedge clk) begin
		if (ld_s2) begin
			prod_s2 <= prod[63:0];
		end
		if (ld_s3) begin
			sum_s3 <= prod_s2 + {{32{origin[31]}}, origin};
		end
	end

	// floor shift, then step up by one for a negative value with a fraction
	always_comb begin
		floor_q = $signed(sum_s3[63:16]);
		q       = floor_q + {47'd0, (sum_s3[63] && (sum_s3[15:0] != 16'd0))};
		if (q[47:31] == {17{q[47]}}) begin
			pixel = q[31:0];
		end else begin
			pixel = q[47] ? PixMin : PixMax;
		end
	end

endmodule

// ===== sv/vtgd_out.sv =====
// Result holding stage: keeps one byte's results and hands them out in order.
`timescale 1ns / 1ps

module vtgd_out
	import vtgd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid_in,
	input  ev_meta_t    meta_in,
	input  logic [31:0] pixel_x,
	input  logic [31:0] pixel_y,
	input  logic        out_stall,
	output logic        out_valid,
	output out_res_t    out_data,
	output logic        ready,
	output logic        busy
);

	logic        have_pt_q, have_fl_q;
	logic [1:0]  pt_kind_q, fl_kind_q;
	logic [31:0] pt_x_q, pt_y_q;
	logic [15:0] pt_cnt_q, fl_cnt_q;
	logic        take;

	assign busy      = have_pt_q || have_fl_q;
	assign out_valid = busy;
	assign take      = out_valid && !out_stall;
	assign ready     = !busy || (take && !(have_pt_q && have_fl_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_pt_q <= 1'b0;
			have_fl_q <= 1'b0;
		end else if (ready) begin
			have_pt_q <= valid_in && meta_in.pt_valid;
			have_fl_q <= valid_in && meta_in.fl_valid;
		end else if (take) begin
			have_pt_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ready) begin
			pt_kind_q <= meta_in.pt_kind;
			pt_cnt_q  <= meta_in.pt_count;
			pt_x_q    <= pixel_x;
			pt_y_q    <= pixel_y;
			fl_kind_q <= meta_in.fl_kind;
			fl_cnt_q  <= meta_in.fl_count;
		end
	end

	always_comb begin
		if (have_pt_q) begin
			out_data.event_res     = pt_kind_q;
			out_data.pixel_x       = pt_x_q;
			out_data.pixel_y       = pt_y_q;
			out_data.path_vertices = pt_cnt_q;
			out_data.run_last      = !have_fl_q;
		end else begin
			out_data.event_res     = fl_kind_q;
			out_data.pixel_x       = '0;
			out_data.pixel_y       = '0;
			out_data.path_vertices = fl_cnt_q;
			out_data.run_last      = 1'b1;
		end
	end

endmodule

// ===== sv/vector_tile_geometry_decoder_top.sv =====
// Vector tile geometry decoder top level: byte parser, two-axis scaler, result stage.
// Throughput: one byte per cycle unless the result channel stalls or a byte with
//   two results holds the single result port for both of them.
// Reset: arst_n clears parse state, cursors, path count, stage valids and registers.
`timescale 1ns / 1ps

module vector_tile_geometry_decoder_top
	import vtgd_pkg::*;
#(
	parameter int MAX_VERTEX_CAP = 65535
) (
	input  logic        clk,
	input  logic        arst_n,
	// byte request channel
	input  logic        in_valid,
	output logic        in_stall,
	input  in_req_t     in_data,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output out_res_t    out_data,
	// configuration writes
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [31:0] cfg_wdata
);

	// Configuration registers
	logic [31:0] origin_x_q, origin_y_q, scale_q;
	logic [1:0]  geom_type_q;
	logic [15:0] vertex_cap_q;

	// Pipeline: s1 parser output, s2 products, s3 sums, then the result stage
	logic        accept;
	logic        valid_s1, valid_s2, valid_s3;
	logic        ready_s1, ready_s2, ready_s3, ready_h;
	logic        h_busy;
	ev_meta_t    meta_s1, meta_s2, meta_s3;
	logic [31:0] cursor_x_s1, cursor_y_s1;
	logic [31:0] pixel_x, pixel_y;

	// Each stage moves when it is empty or the stage after it moves; bubbles collapse
	assign ready_s3 = !valid_s3 || ready_h;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_stall = !ready_s1;
	assign accept   = in_valid && !in_stall;

	// Register writes; an index past the list is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q   <= '0;
			origin_y_q   <= '0;
			scale_q      <= 32'h0001_0000;
			geom_type_q  <= GEOM_UNKNOWN;
			vertex_cap_q <= 16'hffff;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_ORIGIN_X:   origin_x_q   <= cfg_wdata;
				CFG_ORIGIN_Y:   origin_y_q   <= cfg_wdata;
				CFG_SCALE:      scale_q      <= cfg_wdata;
				CFG_GEOM_TYPE:  geom_type_q  <= cfg_wdata[1:0];
				CFG_VERTEX_CAP: vertex_cap_q <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	// Parse the byte and register its events and cursor in s1
	vtgd_parser #(
		.MAX_VERTEX_CAP(MAX_VERTEX_CAP)
	) u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.req          (in_data),
		.ready_s1     (ready_s1),
		.geometry_type(geom_type_q),
		.vertex_cap   (vertex_cap_q),
		.valid_s1     (valid_s1),
		.meta_s1      (meta_s1),
		.cursor_x_s1  (cursor_x_s1),
		.cursor_y_s1  (cursor_y_s1)
	);

	// Scale both axes in parallel; pixels come out beside s3
	vtgd_scaler u_scale_x (
		.clk      (clk),
		.ld_s2    (ready_s2),
		.ld_s3    (ready_s3),
		.cursor_s1(cursor_x_s1),
		.scale    (scale_q),
		.origin   (origin_x_q),
		.pixel    (pixel_x)
	);

	vtgd_scaler u_scale_y (
		.clk      (clk),
		.ld_s2    (ready_s2),
		.ld_s3    (ready_s3),
		.cursor_s1(cursor_y_s1),
		.scale    (scale_q),
		.origin   (origin_y_q),
		.pixel    (pixel_y)
	);

	// Advance stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
			if (ready_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	// Carry event descriptors alongside the arithmetic
	always_ff @(posedge clk) begin
		if (ready_s2) begin
			meta_s2 <= meta_s1;
		end
		if (ready_s3) begin
			meta_s3 <= meta_s2;
		end
	end

	// Hold one byte's results and hand them out point first, flush second
	vtgd_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_in (valid_s3),
		.meta_in  (meta_s3),
		.pixel_x  (pixel_x),
		.pixel_y  (pixel_y),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.out_data (out_data),
		.ready    (ready_h),
		.busy     (h_busy)
	);

`ifndef SYNTHESIS
	// A stall on the input only comes from a full pipeline
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && valid_s3 && h_busy))
		else $error("input stalled with a free pipeline slot");

	// A stage only holds a byte that produced at least one result
	a_s1_has_event: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (meta_s1.pt_valid || meta_s1.fl_valid))
		else $error("empty request entered the pipeline");

	// A flush is always the final result of its byte and carries no pixel
	a_flush_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (out_data.event_res == EV_LINE || out_data.event_res == EV_POLY))
		|-> (out_data.run_last && out_data.pixel_x == 32'sd0 && out_data.pixel_y == 32'sd0))
		else $error("flush result not last or has pixel data");

	// A marker never reports a path count
	a_marker_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.event_res == EV_MARKER) |-> (out_data.path_vertices == 16'd0))
		else $error("point marker with nonzero path count");
`endif

endmodule
